// ===== rtl/core/ffha_pkg.sv =====
// Package for the first-fit heap allocator core.
// Holds arena geometry, status codes and the table entry type; no dependencies.
`default_nettype none
package ffha_pkg;
    localparam int ARENA_BYTES  = 16384;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W = 15;
    localparam int ADDR_W = 21;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              free_mark;
        logic [SIZE_W-1:0] size;
    } entry_t;
endpackage
`default_nettype wire

// ===== rtl/core/ffha_table_ram.sv =====
// Block table memory: one write port, one read port, registered read data.
// Depends on ffha_pkg.
`default_nettype none
module ffha_table_ram (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ffha_pkg::IDX_W-1:0] waddr,
    input  wire ffha_pkg::entry_t      wdata,
    input  wire logic [ffha_pkg::IDX_W-1:0] raddr,
    output ffha_pkg::entry_t           rdata
);
    import ffha_pkg::*;

    entry_t mem [MAX_BLOCKS];

    // synchronous write and read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator top level: sequencer around the block table memory.
// Depends on ffha_pkg and ffha_table_ram.
//
// Usage: one request beat on s_axis (opcode, size, offset) gives one response
// beat on m_axis (status, payload_offset). Entries are kept in one memory of
// MAX_BLOCKS rows; entries at or beyond the block count are never used.
// Allocate walks the table entry by entry until a fit, then a split shifts the
// tail up one entry at a time. Free walks to the offset, then compacts the table
// in one pass that merges free neighbors. The walk over the single read port
// sets the rate; the worst case is a free of the last block in a full table.
// One item is in flight at a time; s_axis_tready is low while busy or while a
// result waits. A stalled receiver holds the response in the output register.
// Reset: count is 1 and row 0 is written as one free block of arena less a
// header during the first cycle after reset; no request is taken in that cycle.
`default_nettype none
module first_fit_heap_allocator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [0] opcode, [15:1] alloc_size, [29:16] release_offset
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [1:0] status, [15:2] payload_offset
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ARD, S_ACHK, S_SHRD, S_SHWR, S_FRD, S_FCHK,
        S_CRD, S_CCHK, S_DONE
    } state_t;

    state_t             state_reg;
    logic               op_reg;
    logic [SIZE_W-1:0]  req_reg;
    logic [13:0]        rel_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   i_reg;      // read index
    logic [CNT_W-1:0]   w_reg;      // write index for compaction
    logic [ADDR_W-1:0]  addr_reg;
    logic [IDX_W-1:0]   fit_reg;
    logic [SIZE_W-1:0]  rem_reg;
    entry_t             acc_reg;    // pending merged entry during compaction
    logic               acc_v_reg;
    logic [1:0]         st_reg;
    logic [13:0]        off_reg;
    logic               outv_reg;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
    entry_t             rdata;

    ffha_table_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [ADDR_W-1:0] pay_addr;
    logic [SIZE_W+1:0] need;
    logic [SIZE_W:0]   merged;
    assign pay_addr = addr_reg + ADDR_W'(HEADER_BYTES);
    assign need     = (SIZE_W+2)'(req_reg) + (SIZE_W+2)'(HEADER_BYTES);
    assign merged   = (SIZE_W+1)'(acc_reg.size) + (SIZE_W+1)'(rdata.size)
                    + (SIZE_W+1)'(HEADER_BYTES);

    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = {off_reg, st_reg};

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg[IDX_W-1:0];
        wdata = rdata;
        raddr = i_reg[IDX_W-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{free_mark: 1'b1, size: SIZE_W'(ARENA_BYTES - HEADER_BYTES)};
            end
            S_ACHK:
            begin
                if (rdata.free_mark && rdata.size >= req_reg)
                begin
                    we    = 1'b1;
                    wdata = '{free_mark: 1'b0, size: rdata.size};
                    if ((SIZE_W+2)'(rdata.size) > need && count_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        wdata.size = req_reg;
                    end
                end
            end
            S_SHRD:
            begin
                raddr = IDX_W'(i_reg - 1'b1);
            end
            S_SHWR:
            begin
                we = 1'b1;
                if (i_reg == CNT_W'(fit_reg) + 1'b1)
                begin
                    wdata = '{free_mark: 1'b1, size: rem_reg};
                end
            end
            S_FCHK:
            begin
                if (pay_addr == ADDR_W'(rel_reg) && !rdata.free_mark)
                begin
                    we    = 1'b1;
                    wdata = '{free_mark: 1'b1, size: rdata.size};
                end
            end
            S_CCHK:
            begin
                // flush pending entry when current one does not merge into it
                if (acc_v_reg && !(acc_reg.free_mark && rdata.free_mark))
                begin
                    we    = 1'b1;
                    waddr = w_reg[IDX_W-1:0];
                    wdata = acc_reg;
                end
            end
            S_DONE:
            begin
                we    = acc_v_reg;
                waddr = w_reg[IDX_W-1:0];
                wdata = acc_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= CNT_W'(1);
            outv_reg  <= 1'b0;
            acc_v_reg <= 1'b0;
        end
        else
        begin
            if (outv_reg && m_axis_tready)
            begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= s_axis_tdata[0];
                        req_reg   <= s_axis_tdata[15:1];
                        rel_reg   <= s_axis_tdata[29:16];
                        i_reg     <= '0;
                        addr_reg  <= '0;
                        st_reg    <= (s_axis_tdata[0] == OP_ALLOC) ? ST_NOSPACE : ST_BADFREE;
                        off_reg   <= '0;
                        acc_v_reg <= 1'b0;
                        state_reg <= (s_axis_tdata[0] == OP_ALLOC) ? S_ARD : S_FRD;
                    end
                end
                S_ARD:
                begin
                    state_reg <= (i_reg < count_reg) ? S_ACHK : S_DONE;
                end
                S_ACHK:
                begin
                    if (rdata.free_mark && rdata.size >= req_reg)
                    begin
                        st_reg  <= ST_OK;
                        off_reg <= pay_addr[13:0];
                        if ((SIZE_W+2)'(rdata.size) > need && count_reg < CNT_W'(MAX_BLOCKS))
                        begin
                            fit_reg   <= i_reg[IDX_W-1:0];
                            rem_reg   <= SIZE_W'((SIZE_W+2)'(rdata.size) - need);
                            i_reg     <= count_reg;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_SHRD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        addr_reg  <= pay_addr + ADDR_W'(rdata.size);
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    if (i_reg == CNT_W'(fit_reg) + 1'b1)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_SHRD;
                    end
                end
                S_FRD:
                begin
                    state_reg <= (i_reg < count_reg) ? S_FCHK : S_DONE;
                end
                S_FCHK:
                begin
                    if (pay_addr == ADDR_W'(rel_reg))
                    begin
                        if (!rdata.free_mark)
                        begin
                            st_reg    <= ST_OK;
                            i_reg     <= '0;
                            w_reg     <= '0;
                            state_reg <= S_CRD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else if (pay_addr > ADDR_W'(rel_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        addr_reg  <= pay_addr + ADDR_W'(rdata.size);
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= (i_reg < count_reg) ? S_CCHK : S_DONE;
                end
                S_CCHK:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_CRD;
                    if (acc_v_reg && acc_reg.free_mark && rdata.free_mark)
                    begin
                        acc_reg.size <= SIZE_W'(merged);
                    end
                    else
                    begin
                        acc_reg   <= rdata;
                        acc_v_reg <= 1'b1;
                        if (acc_v_reg)
                        begin
                            w_reg <= w_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (op_reg == OP_FREE && st_reg == ST_OK)
                    begin
                        count_reg <= w_reg + 1'b1;
                    end
                    acc_v_reg <= 1'b0;
                    outv_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE && !m_axis_tvalid)
        else $error("accept while busy");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> m_axis_tvalid)
        else $error("result not raised");
    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[15:2] == '0)
        else $error("offset on failed request");
endmodule
`default_nettype wire

// ===== verif/first_fit_heap_allocator_core_checker.sv =====
// Checker for the first-fit heap allocator core: watches both stream channels,
// predicts each response from its own block table and compares. Depends on ffha_pkg.
`timescale 1ns / 100ps
module first_fit_heap_allocator_core_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [0] opcode, [15:1] alloc_size, [29:16] release_offset
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [1:0] status, [15:2] payload_offset
    output int               fail_count,
    output int               pending_count
);
    import ffha_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] offset;
    } response_t;

    // Block table copy
    int        blk_size [MAX_BLOCKS];
    bit        blk_free [MAX_BLOCKS];
    int        blk_cnt;
    response_t resp_q[$];

    assign pending_count = resp_q.size();

    function automatic void table_reset();
        foreach (blk_size[k])
        begin
            blk_size[k] = 0;
            blk_free[k] = 0;
        end
        blk_size[0] = ARENA_BYTES - HEADER_BYTES;
        blk_free[0] = 1;
        blk_cnt     = 1;
    endfunction

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < blk_cnt; k++)
        begin
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
        blk_size[blk_cnt] = 0;
        blk_free[blk_cnt] = 0;
    endfunction

    // Merge every run of adjacent free blocks
    function automatic void merge_free_runs();
        int i;
        i = 0;
        while (i + 1 < blk_cnt)
        begin
            if (blk_free[i] && blk_free[i+1])
            begin
                blk_size[i] += blk_size[i+1] + HEADER_BYTES;
                drop_entry(i + 1);
            end
            else
                i++;
        end
    endfunction

    function automatic response_t heap_request(logic op, int req, int rel);
        response_t r;
        int        addr;
        int        pay;
        r    = '{status: ST_NOSPACE, offset: '0};
        addr = 0;
        if (op == OP_ALLOC)
        begin
            for (int i = 0; i < blk_cnt; i++)
            begin
                if (blk_free[i] && blk_size[i] >= req)
                begin
                    if (blk_size[i] > req + HEADER_BYTES && blk_cnt < MAX_BLOCKS)
                    begin
                        for (int k = blk_cnt; k > i + 1; k--)
                        begin
                            blk_size[k] = blk_size[k-1];
                            blk_free[k] = blk_free[k-1];
                        end
                        blk_size[i+1] = blk_size[i] - req - HEADER_BYTES;
                        blk_free[i+1] = 1;
                        blk_cnt++;
                        blk_size[i] = req;
                    end
                    blk_free[i] = 0;
                    r.status = ST_OK;
                    r.offset = 14'(addr + HEADER_BYTES);
                    break;
                end
                addr += HEADER_BYTES + blk_size[i];
            end
        end
        else
        begin
            r.status = ST_BADFREE;
            for (int i = 0; i < blk_cnt; i++)
            begin
                pay = addr + HEADER_BYTES;
                if (pay == rel)
                begin
                    if (!blk_free[i])
                    begin
                        blk_free[i] = 1;
                        merge_free_runs();
                        r.status = ST_OK;
                    end
                    break;
                end
                if (pay > rel)
                    break;
                addr = pay + blk_size[i];
            end
        end
        return r;
    endfunction

    initial table_reset();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reset();
            resp_q.delete();
            fail_count <= 0;
        end
        else
        begin
            // Response beat against oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (resp_q.size() == 0)
                begin
                    $error("unexpected response beat 0x%h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    response_t e;
                    e = resp_q.pop_front();
                    if (m_axis_tdata[1:0] !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, m_axis_tdata[1:0]);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_axis_tdata[15:2] !== e.offset)
                    begin
                        $error("payload_offset: expected %0d, actual %0d",
                               e.offset, m_axis_tdata[15:2]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Request beat
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(heap_request(s_axis_tdata[0], int'(s_axis_tdata[15:1]),
                                              int'(s_axis_tdata[29:16])));
        end
    end
endmodule

// ===== verif/first_fit_heap_allocator_core_tb.sv =====
// Testbench top for the first-fit heap allocator core: drives alloc/free beats
// with random gaps and stalls, instantiates the core and the checker.
`timescale 1ns / 100ps
module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [0] opcode, [15:1] alloc_size, [29:16] release_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;        // [1:0] status, [15:2] payload_offset
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          calm = 0;            // no idling on either side
    bit          hold_off = 0;        // long receiver stall
    bit          timed_out = 0;
    int          granted[$];          // payload offsets handed out

    always #10 clk = ~clk;

    first_fit_heap_allocator_core dut (.*);

    first_fit_heap_allocator_core_checker chk (.*);

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 0;
        else
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == ST_OK &&
            m_axis_tdata[15:2] != 0)
            granted.push_back(int'(m_axis_tdata[15:2]));
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES && !timed_out)
        begin
            timed_out = 1;
            $display("first_fit_heap_allocator_core regression: fail");
            $finish;
        end
    end

    // Valid stays up after the beat; drain() lowers it, the next call only for a random gap
    task automatic send_beat(logic op, int size, int offs);
        if (!calm)
            while ($urandom_range(99) < 17)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b00, 14'(offs), 15'(size), op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Random free target: mostly a live grant, sometimes noise
    task automatic random_free();
        int pick;
        int offs;
        pick = $urandom_range(99);
        if (pick < 75 && granted.size() != 0)
        begin
            int j;
            j = $urandom_range(granted.size() - 1);
            offs = granted[j];
            granted.delete(j);
        end
        else if (pick < 85)
            offs = $urandom_range(16383);
        else
            offs = 16 * $urandom_range(1023);
        send_beat(OP_FREE, $urandom_range(32767), offs);
    endtask

    task automatic random_alloc();
        int size;
        case ($urandom_range(9))
            0:       size = $urandom_range(32767);
            1:       size = $urandom_range(16384);
            2:       size = $urandom_range(16);
            default: size = $urandom_range(600);
        endcase
        send_beat(OP_ALLOC, size, $urandom_range(16383));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, exact/near fit, zero size, oversized, bad frees
        send_beat(OP_ALLOC, 32767, 16383);
        send_beat(OP_ALLOC, 16384, 0);
        send_beat(OP_ALLOC, 16368, 0);           // exact fit, whole arena
        send_beat(OP_FREE, 0, 16);
        send_beat(OP_FREE, 0, 16);               // double free
        send_beat(OP_ALLOC, 16360, 0);           // near fit, whole block
        send_beat(OP_FREE, 0, 16);
        send_beat(OP_ALLOC, 0, 0);               // zero-byte payload
        send_beat(OP_ALLOC, 100, 0);
        send_beat(OP_FREE, 0, 40);               // inside a payload
        send_beat(OP_FREE, 0, 16383);            // past the last payload
        send_beat(OP_FREE, 0, 0);
        send_beat(OP_FREE, 0, 32);               // merge around
        send_beat(OP_FREE, 0, 16);
        send_beat(OP_ALLOC, 10, 0);
        send_beat(OP_ALLOC, 20, 0);
        send_beat(OP_FREE, 0, 16);
        send_beat(OP_FREE, 32767, 42);           // frees middle, merges both sides
        drain();

        // Table full: many zero-size grants
        for (int i = 0; i < 70; i++)
            send_beat(OP_ALLOC, 0, 0);
        send_beat(OP_ALLOC, 50, 0);
        drain();
        for (int i = 0; i < 64; i++)
            send_beat(OP_FREE, 0, 16 + 16 * i);
        drain();
        granted.delete();

        // Long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 8; i++)
                random_alloc();
        join
        drain();

        // Random mix; calm stretch in the middle
        for (int i = 0; i < 1200; i++)
        begin
            calm = (i >= 400 && i < 550);
            if ($urandom_range(99) < 55)
                random_alloc();
            else
                random_free();
            if (i % 300 == 299)
                drain();
        end
        calm = 0;
        drain();
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("first_fit_heap_allocator_core regression: pass");
        else
            $display("first_fit_heap_allocator_core regression: fail");
        $finish;
    end
endmodule

// ===== first_fit_heap_allocator_core.f =====
rtl/core/ffha_pkg.sv
rtl/core/ffha_table_ram.sv
rtl/core/first_fit_heap_allocator_core.sv
verif/first_fit_heap_allocator_core_checker.sv
verif/first_fit_heap_allocator_core_tb.sv
